@@ sv/sgb_pkg.sv @@
package sgb_pkg;

  localparam int MAX_RADIUS = 5;
  localparam int MAX_WIDTH  = 1024;
  localparam int HIST_ROWS  = 2 * MAX_RADIUS;
  localparam int WIN_LEN    = 2 * MAX_RADIUS + 1;

  localparam int PIX_W     = 8;
  localparam int WGT_W     = 16;
  localparam int RAD_W     = 3;
  localparam int LW_W      = 11;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROWS_W    = $clog2(MAX_RADIUS + 1);
  localparam int TIX_W     = $clog2(WIN_LEN);

  // vertical pass: exact sum of up to WIN_LEN weighted pixels
  localparam int VP_PAIR_W = PIX_W + 1;
  localparam int VP_PROD_W = VP_PAIR_W + WGT_W;
  localparam int VS_W      = PIX_W + WGT_W + $clog2(WIN_LEN + 1);

  // horizontal pass
  localparam int HP_PAIR_W = VS_W + 1;
  localparam int HP_PROD_W = HP_PAIR_W + WGT_W;
  localparam int HP_ACC_W  = HP_PROD_W + $clog2(MAX_RADIUS + 1);
  localparam int FRAC_W    = 2 * WGT_W;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WCENTER = 3'd2;

  localparam logic [RAD_W-1:0] RADIUS_RST = 3'd1;
  localparam logic [LW_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [WGT_W-1:0] WCENTER_RST = 16'd32768;
  localparam logic [WGT_W-1:0] WDIST1_RST  = 16'd16384;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef logic [MAX_RADIUS:0][WGT_W-1:0] weights_t;
  typedef logic [HIST_ROWS-1:0][PIX_W-1:0] hist_t;
  typedef logic [WIN_LEN-1:0][VS_W-1:0] window_t;

  typedef struct packed {
    logic emit;
    logic row_end;
    logic last;
  } tag_t;

  typedef struct packed {
    logic vld;
    logic rpt;
    logic col0;
    tag_t tag;
  } slot_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             last;
  } out_beat_t;

endpackage

@@ sv/sgb_if.sv @@
interface sgb_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [sgb_pkg::PIX_W-1:0] pixel_in;
  logic                      frame_start;

  modport source(output valid, op, pixel_in, frame_start, input ready);
  modport sink(input valid, op, pixel_in, frame_start, output ready);
endinterface

interface sgb_out_if;
  logic                      valid;
  logic                      ready;
  logic [sgb_pkg::PIX_W-1:0] pixel_out;
  logic                      row_end;
  logic                      last;

  modport source(output valid, pixel_out, row_end, last, input ready);
  modport sink(input valid, pixel_out, row_end, last, output ready);
endinterface

@@ sv/sgb_ram.sv @@
module sgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/sgb_cell.sv @@
module sgb_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     load_i,
  input  logic [sgb_pkg::VS_W-1:0] fill_i,
  input  logic [sgb_pkg::VS_W-1:0] prev_i,
  output logic [sgb_pkg::VS_W-1:0] value_o
);
  import sgb_pkg::*;

  logic [VS_W-1:0] value_d, value_q;

  // left border loads the whole row of cells with one sum
  assign value_d = load_i ? fill_i : prev_i;
  assign value_o = value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else if (en_i) begin
      value_q <= value_d;
    end
  end

endmodule

@@ sv/sgb_vpass.sv @@
module sgb_vpass (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sgb_pkg::slot_t            slot_i,
  input  logic [sgb_pkg::COL_W-1:0] col_i,
  input  logic                      op_i,
  input  logic [sgb_pkg::PIX_W-1:0] pix_i,
  input  logic                      rows0_i,
  input  logic [sgb_pkg::RAD_W-1:0] rad_i,
  input  sgb_pkg::weights_t         wgt_i,
  output sgb_pkg::slot_t            slot_o,
  output logic [sgb_pkg::VS_W-1:0]  v_o
);
  import sgb_pkg::*;

  slot_t            slot1_q, slot2_q, slot3_q, slot4_q;
  logic [COL_W-1:0] col1_q;
  logic             op1_q;
  logic [PIX_W-1:0] pix1_q;
  logic             rows01_q;

  hist_t            ram_rdata, hist_raw, hist_eff, hist_new;
  logic             wr_vld_d, wr_vld_q;
  logic [COL_W-1:0] wr_addr_q;
  hist_t            wr_data_q;
  logic [PIX_W-1:0] pix_eff;
  logic [WIN_LEN-1:0][PIX_W-1:0] taps;

  logic [PIX_W-1:0]                       cen_d, cen2_q;
  logic [MAX_RADIUS-1:0][VP_PAIR_W-1:0]   pair_d, pair2_q;
  logic [MAX_RADIUS:0][VP_PROD_W-1:0]     prod_d, prod3_q;
  logic [VS_W-1:0]                        sum_d, v_q;

  sgb_ram #(
    .WIDTH($bits(hist_t)),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (wr_vld_d),
    .waddr_i(col1_q),
    .wdata_i(hist_new),
    .raddr_i(col_i),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    // forward the column written in the cycle this beat's read was issued
    hist_raw = (wr_vld_q && (wr_addr_q == col1_q)) ? wr_data_q : ram_rdata;
    pix_eff  = (op1_q == OP_FLUSH) ? hist_raw[0] : pix1_q;
    for (int i = 0; i < HIST_ROWS; i++) begin
      hist_eff[i] = rows01_q ? pix_eff : hist_raw[i];
    end
    taps[0]     = pix_eff;
    hist_new[0] = pix_eff;
    for (int t = 1; t < WIN_LEN; t++) begin
      taps[t] = hist_eff[t-1];
    end
    for (int i = 1; i < HIST_ROWS; i++) begin
      hist_new[i] = hist_eff[i-1];
    end
    wr_vld_d = slot1_q.vld && !slot1_q.rpt;
    cen_d    = taps[TIX_W'(rad_i)];
    for (int d = 1; d <= MAX_RADIUS; d++) begin
      if (RAD_W'(d) <= rad_i) begin
        pair_d[d-1] = VP_PAIR_W'(taps[TIX_W'(rad_i) - TIX_W'(d)])
                    + VP_PAIR_W'(taps[TIX_W'(rad_i) + TIX_W'(d)]);
      end else begin
        pair_d[d-1] = '0;
      end
    end
  end

  always_comb begin
    prod_d[0] = VP_PROD_W'(wgt_i[0] * cen2_q);
    for (int d = 1; d <= MAX_RADIUS; d++) begin
      prod_d[d] = wgt_i[d] * pair2_q[d-1];
    end
  end

  always_comb begin
    sum_d = '0;
    for (int d = 0; d <= MAX_RADIUS; d++) begin
      sum_d = sum_d + VS_W'(prod3_q[d]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot1_q  <= '0;
      slot2_q  <= '0;
      slot3_q  <= '0;
      slot4_q  <= '0;
      wr_vld_q <= 1'b0;
    end else begin
      slot1_q  <= slot_i;
      slot2_q  <= slot1_q;
      slot3_q  <= slot2_q;
      slot4_q  <= slot3_q;
      wr_vld_q <= wr_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col1_q    <= col_i;
    op1_q     <= op_i;
    pix1_q    <= pix_i;
    rows01_q  <= rows0_i;
    wr_addr_q <= col1_q;
    wr_data_q <= hist_new;
    cen2_q    <= cen_d;
    pair2_q   <= pair_d;
    prod3_q   <= prod_d;
    v_q       <= sum_d;
  end

  assign slot_o = slot4_q;
  assign v_o    = v_q;

endmodule

@@ sv/sgb_hpass.sv @@
module sgb_hpass (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sgb_pkg::window_t          win_i,
  input  logic [sgb_pkg::RAD_W-1:0] rad_i,
  input  sgb_pkg::weights_t         wgt_i,
  input  sgb_pkg::tag_t             tag_i,
  output logic                      res_vld_o,
  output sgb_pkg::out_beat_t        res_o
);
  import sgb_pkg::*;

  tag_t                                 tag1_q, tag2_q;
  logic [VS_W-1:0]                      cen_d, cen1_q;
  logic [MAX_RADIUS-1:0][HP_PAIR_W-1:0] pair_d, pair1_q;
  logic [MAX_RADIUS:0][HP_PROD_W-1:0]   prod_d, prod2_q;
  logic [HP_ACC_W-1:0]                  acc;
  logic [HP_ACC_W-FRAC_W-1:0]           whole;
  logic                                 res_vld_q;
  out_beat_t                            res_d, res_q;

  always_comb begin
    cen_d = win_i[TIX_W'(rad_i)];
    for (int d = 1; d <= MAX_RADIUS; d++) begin
      if (RAD_W'(d) <= rad_i) begin
        pair_d[d-1] = HP_PAIR_W'(win_i[TIX_W'(rad_i) - TIX_W'(d)])
                    + HP_PAIR_W'(win_i[TIX_W'(rad_i) + TIX_W'(d)]);
      end else begin
        pair_d[d-1] = '0;
      end
    end
  end

  always_comb begin
    prod_d[0] = HP_PROD_W'(wgt_i[0] * cen1_q);
    for (int d = 1; d <= MAX_RADIUS; d++) begin
      prod_d[d] = wgt_i[d] * pair1_q[d-1];
    end
  end

  always_comb begin
    acc = '0;
    for (int d = 0; d <= MAX_RADIUS; d++) begin
      acc = acc + HP_ACC_W'(prod2_q[d]);
    end
    whole = acc[HP_ACC_W-1:FRAC_W];
    // truncate the fraction, saturate the integer part
    res_d.pixel_out = (whole > (HP_ACC_W-FRAC_W)'(8'hff)) ? 8'hff : whole[PIX_W-1:0];
    res_d.row_end   = tag2_q.row_end;
    res_d.last      = tag2_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q    <= '0;
      tag2_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      tag1_q    <= tag_i;
      tag2_q    <= tag1_q;
      res_vld_q <= tag2_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    cen1_q  <= cen_d;
    pair1_q <= pair_d;
    prod2_q <= prod_d;
    res_q   <= res_d;
  end

  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

endmodule

@@ sv/separable_gaussian_blur.sv @@
// Throughput: one pixel per cycle unless input stalls; after the last pixel of a line,
// input stalls while radius right-edge repeats are pushed through the window cells.
// Results wait in a 16-entry output queue; input also stalls once the results
// in flight and queued reach its depth.
// Reset (rst_ni, async, active low) restores register defaults and clears
// column and row counters, the window cells and all control state.
module separable_gaussian_blur (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sgb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sgb_pkg::CFG_W-1:0]     cfg_data_i,
  sgb_in_if.sink                        in_ch,
  sgb_out_if.source                     out_ch
);
  import sgb_pkg::*;

  // configuration
  logic [RAD_W-1:0] rad_q, rad_eff;
  logic [LW_W-1:0]  lw_q;
  weights_t         wgt_q;
  logic [CFG_IDX_W-1:0] wsel;

  assign wsel = cfg_idx_i - CFG_WCENTER;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= RADIUS_RST;
      lw_q  <= WIDTH_RST;
      wgt_q <= {{((MAX_RADIUS - 1) * WGT_W){1'b0}}, WDIST1_RST, WCENTER_RST};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIUS: rad_q <= cfg_data_i[RAD_W-1:0];
        CFG_WIDTH:  lw_q  <= cfg_data_i[LW_W-1:0];
        default:    wgt_q[wsel] <= cfg_data_i[WGT_W-1:0];
      endcase
    end
  end

  // input sequencing
  logic [COL_W-1:0]  col_d, col_q, col_base, col_cur, wlast;
  logic [ROWS_W-1:0] rows_d, rows_q, rows_base;
  logic              last_col, active, accept, issue_rpt, has_room;
  logic              bst_d, bst_q, bst_act_d, bst_act_q;
  logic [RAD_W-1:0]  bst_e_d, bst_e_q;
  logic [COL_W-1:0]  bst_c_d, bst_c_q;
  logic [PEND_W-1:0] pend_d, pend_q;
  slot_t             slot_s0;
  logic              pop;

  assign rad_eff  = (rad_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : rad_q;
  assign has_room = pend_q < PEND_W'(FIFO_DEPTH);
  assign in_ch.ready = !bst_q && has_room;
  assign accept    = in_ch.valid && in_ch.ready;
  assign issue_rpt = bst_q && has_room;

  always_comb begin
    if (lw_q == '0) begin
      wlast = '0;
    end else if (lw_q > LW_W'(MAX_WIDTH)) begin
      wlast = COL_W'(MAX_WIDTH - 1);
    end else begin
      wlast = COL_W'(lw_q - 1'b1);
    end
    col_base  = in_ch.frame_start ? '0 : col_q;
    rows_base = in_ch.frame_start ? '0 : rows_q;
    col_cur   = (col_base >= wlast) ? wlast : col_base;
    last_col  = col_cur == wlast;
    active    = int'(rows_base) >= int'(rad_eff);

    slot_s0   = '0;
    col_d     = col_q;
    rows_d    = rows_q;
    bst_d     = bst_q;
    bst_e_d   = bst_e_q;
    bst_act_d = bst_act_q;
    bst_c_d   = bst_c_q;

    if (accept) begin
      slot_s0.vld         = 1'b1;
      slot_s0.col0        = col_cur == '0;
      slot_s0.tag.emit    = active && (int'(col_cur) >= int'(rad_eff));
      slot_s0.tag.row_end = last_col && (rad_eff == '0);
      slot_s0.tag.last    = !(last_col && (rad_eff != '0));
      if (last_col) begin
        col_d  = '0;
        rows_d = (int'(rows_base) < MAX_RADIUS) ? rows_base + 1'b1 : rows_base;
        if (rad_eff != '0) begin
          bst_d     = 1'b1;
          bst_e_d   = RAD_W'(1);
          bst_act_d = active;
          bst_c_d   = col_cur;
        end
      end else begin
        col_d  = col_cur + 1'b1;
        rows_d = rows_base;
      end
    end else if (issue_rpt) begin
      // right edge: push the last column's sum again
      slot_s0.vld         = 1'b1;
      slot_s0.rpt         = 1'b1;
      slot_s0.tag.emit    = bst_act_q && (int'(bst_c_q) + int'(bst_e_q) >= int'(rad_eff));
      slot_s0.tag.row_end = bst_e_q == rad_eff;
      slot_s0.tag.last    = bst_e_q == rad_eff;
      if (bst_e_q == rad_eff) begin
        bst_d = 1'b0;
      end else begin
        bst_e_d = bst_e_q + 1'b1;
      end
    end

    pend_d = pend_q + PEND_W'(slot_s0.tag.emit) - PEND_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      rows_q    <= '0;
      bst_q     <= 1'b0;
      bst_e_q   <= '0;
      bst_act_q <= 1'b0;
      bst_c_q   <= '0;
      pend_q    <= '0;
    end else begin
      col_q     <= col_d;
      rows_q    <= rows_d;
      bst_q     <= bst_d;
      bst_e_q   <= bst_e_d;
      bst_act_q <= bst_act_d;
      bst_c_q   <= bst_c_d;
      pend_q    <= pend_d;
    end
  end

  // vertical pass
  slot_t           slot_w;
  logic [VS_W-1:0] v_w, v_push, v_last_q;

  sgb_vpass u_vpass (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .slot_i (slot_s0),
    .col_i  (col_cur),
    .op_i   (in_ch.op),
    .pix_i  (in_ch.pixel_in),
    .rows0_i(rows_base == '0),
    .rad_i  (rad_eff),
    .wgt_i  (wgt_q),
    .slot_o (slot_w),
    .v_o    (v_w)
  );

  // window of vertical sums, newest in cell 0
  window_t win;
  tag_t    tag_h_q;

  assign v_push = slot_w.rpt ? v_last_q : v_w;

  for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
    sgb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (slot_w.vld),
      .load_i (slot_w.col0),
      .fill_i (v_push),
      .prev_i ((i == 0) ? v_push : win[(i == 0) ? 0 : i-1]),
      .value_o(win[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (slot_w.vld && !slot_w.rpt) begin
      v_last_q <= v_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_h_q <= '0;
    end else begin
      tag_h_q <= slot_w.vld ? slot_w.tag : '0;
    end
  end

  // horizontal pass
  logic      res_vld;
  out_beat_t res;

  sgb_hpass u_hpass (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .win_i    (win),
    .rad_i    (rad_eff),
    .wgt_i    (wgt_q),
    .tag_i    (tag_h_q),
    .res_vld_o(res_vld),
    .res_o    (res)
  );

  // output queue; space is reserved at issue so a push never overflows
  out_beat_t          fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PEND_W-1:0]  cnt_q;
  out_beat_t          head;

  assign head           = fifo_q[rd_ptr_q];
  assign out_ch.valid   = cnt_q != '0;
  assign out_ch.pixel_out = head.pixel_out;
  assign out_ch.row_end = head.row_end;
  assign out_ch.last    = head.last;
  assign pop            = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (res_vld) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + PEND_W'(res_vld) - PEND_W'(pop);
    end
  end

endmodule
